// ===== src/bb7_pkg.sv =====
// ----------------------------------------------------------------------------
// bb7_pkg
// Shared types and constants of the 7x7 RGB box blur.
// ----------------------------------------------------------------------------
package bb7_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 4'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } bb7_state_t;

endpackage

// ===== src/bb7_line_store.sv =====
// ----------------------------------------------------------------------------
// bb7_line_store
// Single-port-write, single-port-read line memory with registered read data.
// ----------------------------------------------------------------------------
module bb7_line_store #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/bb7_divider.sv =====
// ----------------------------------------------------------------------------
// bb7_divider
// Restoring divider giving an 8-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module bb7_divider #(
  parameter int SUMW = 14,
  parameter int CNW  = 6
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [SUMW-1:0]         dividend,
  input  logic [CNW-1:0]          divisor,
  output logic                    done,
  output logic [bb7_pkg::CH_W-1:0] quotient
);
  import bb7_pkg::*;

  localparam int EW = ((SUMW > CNW + CH_W) ? SUMW : CNW + CH_W) + 1;
  localparam int BW = $clog2(CH_W);

  logic [EW-1:0]  rem;
  logic [CNW-1:0] dvs;
  logic [BW-1:0]  bit_idx;
  logic           busy;
  logic [EW-1:0]  shifted;

  assign shifted = EW'(dvs) << bit_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bit_idx == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= EW'(dividend);
      dvs      <= divisor;
      bit_idx  <= BW'(CH_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (rem >= shifted) begin
        rem               <= rem - shifted;
        quotient[bit_idx] <= 1'b1;
      end
      bit_idx <= bit_idx - 1'b1;
    end
  end

endmodule

// ===== src/box_blur_7x7_rgb.sv =====
// Operation: a pixel that completes a window is checked, then every window tap is
// visited, with a line-store read for each tap inside the frame, and the sums go
// to an 8-step divider.
// Throughput: one item at a time, the next accepted once that item's result transfers, or once it completes no window.
// Reset: synchronous, clears positions and restores width 640 and height 480.
// ----------------------------------------------------------------------------
// box_blur_7x7_rgb
// Streaming clipped-window box blur on RGB888 frames using line memories.
// ----------------------------------------------------------------------------
module box_blur_7x7_rgb #(
  parameter int MAX_WIDTH     = 2048,
  parameter int MAX_HEIGHT    = 2048,
  parameter int WIN_RADIUS    = 3,
  parameter int LINE_SLOTS    = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic [bb7_pkg::CH_W-1:0]      in_red,
  input  logic [bb7_pkg::CH_W-1:0]      in_green,
  input  logic [bb7_pkg::CH_W-1:0]      in_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bb7_pkg::CH_W-1:0]      out_red,
  output logic [bb7_pkg::CH_W-1:0]      out_green,
  output logic [bb7_pkg::CH_W-1:0]      out_blue,
  output logic                          frame_end,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bb7_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bb7_pkg::CFG_W-1:0]     cfg_data
);
  import bb7_pkg::*;

  localparam int KSIZE = 2 * WIN_RADIUS + 1;
  localparam int KW    = $clog2(KSIZE);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SW    = $clog2(MAXD + 2 * WIN_RADIUS + 1) + 2;
  localparam int CMPW  = ((WW > HW) ? WW : HW) + CFG_W + 1;
  localparam int SLW   = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
  localparam int TW    = SLW + KW + 2;
  localparam int DEPTH = LINE_SLOTS * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUMW  = $clog2(KSIZE * KSIZE * 255 + 1);
  localparam int CNW   = $clog2(KSIZE * KSIZE + 1);

  bb7_state_t state, state_next;

  logic [CFG_W-1:0] cfg_width, cfg_height;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;

  logic [CW-1:0]  in_col, out_col;
  logic [RW-1:0]  in_row, out_row;
  logic [SLW-1:0] in_slot, out_slot;
  logic           frame_loaded;

  logic [KW-1:0]   ky, kx;
  logic            tap_in, tap_last;
  logic [SUMW-1:0] sum_r, sum_g, sum_b;
  logic [CNW-1:0]  count;
  logic            div_start;
  logic            div_done_r, div_done_g, div_done_b;
  logic [CH_W-1:0] q_r, q_g, q_b;
  logic            out_last;

  logic in_xfer, out_xfer, cfg_xfer, cfg_hit;
  logic pixel_take;

  // Clamp the programmed dimensions.
  always_comb begin
    if (cfg_width == '0) begin
      w_eff = WW'(1);
    end else if (CMPW'(cfg_width) > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_eff = HW'(1);
    end else if (CMPW'(cfg_height) > CMPW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height);
    end
  end

  logic signed [SW-1:0] ws, hs, in_row_s, in_col_s, out_row_s, out_col_s;
  logic signed [SW-1:0] near_row, near_col, tap_y, tap_x;
  logic                 win_ready;

  always_comb begin
    ws        = $signed(SW'(w_eff));
    hs        = $signed(SW'(h_eff));
    in_row_s  = $signed(SW'(in_row));
    in_col_s  = $signed(SW'(in_col));
    out_row_s = $signed(SW'(out_row));
    out_col_s = $signed(SW'(out_col));
    near_row  = out_row_s + SW'(WIN_RADIUS);
    if (near_row > hs - SW'(1)) begin
      near_row = hs - SW'(1);
    end
    near_col = out_col_s + SW'(WIN_RADIUS);
    if (near_col > ws - SW'(1)) begin
      near_col = ws - SW'(1);
    end
    win_ready = frame_loaded || (in_row_s > near_row) ||
                ((in_row_s == near_row) && (in_col_s > near_col));
    tap_y = out_row_s + $signed(SW'(ky)) - SW'(WIN_RADIUS);
    tap_x = out_col_s + $signed(SW'(kx)) - SW'(WIN_RADIUS);
  end

  logic signed [TW-1:0] slot_t;
  logic [SLW-1:0]       tap_slot;
  logic                 tap_ok;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [PIX_W-1:0]     rd_data;

  always_comb begin
    slot_t = $signed(TW'(out_slot)) + $signed(TW'(ky)) - TW'(WIN_RADIUS);
    if (slot_t < 0) begin
      slot_t = slot_t + TW'(LINE_SLOTS);
    end else if (slot_t >= $signed(TW'(LINE_SLOTS))) begin
      slot_t = slot_t - TW'(LINE_SLOTS);
    end
    tap_slot = SLW'(slot_t);
    tap_ok   = (tap_y >= 0) && (tap_y < hs) && (tap_x >= 0) && (tap_x < ws);
    rd_addr  = AW'(tap_slot) * AW'(MAX_WIDTH) + AW'(tap_x);
    wr_addr  = AW'(in_slot) * AW'(MAX_WIDTH) + AW'(in_col);
  end

  assign in_xfer    = in_valid && !in_stall;
  assign out_xfer   = out_valid && !out_stall;
  assign cfg_xfer   = cfg_valid && cfg_ready;
  assign cfg_hit    = cfg_xfer &&
                      (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
  assign pixel_take = in_xfer && (command == CMD_PIXEL) && !frame_loaded;
  assign tap_last   = (ky == KW'(KSIZE - 1)) && (kx == KW'(KSIZE - 1));

  // The dividers start in the cycle after the last tap's accumulation so that its sum is included.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= (state == ST_ACC) && tap_last;
    end
  end

  bb7_line_store #(.DEPTH(DEPTH), .AW(AW), .DW(PIX_W)) u_store (
    .clk     (clk),
    .wr_en   (pixel_take),
    .wr_addr (wr_addr),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_en   ((state == ST_READ) && tap_ok),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bb7_divider #(.SUMW(SUMW), .CNW(CNW)) u_div_r (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_r), .divisor(count),
    .done(div_done_r), .quotient(q_r)
  );
  bb7_divider #(.SUMW(SUMW), .CNW(CNW)) u_div_g (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_g), .divisor(count),
    .done(div_done_g), .quotient(q_g)
  );
  bb7_divider #(.SUMW(SUMW), .CNW(CNW)) u_div_b (
    .clk(clk), .rst(rst), .start(div_start), .dividend(sum_b), .divisor(count),
    .done(div_done_b), .quotient(q_b)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer && (command == CMD_FLUSH || !frame_loaded)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: state_next = win_ready ? ST_READ : ST_IDLE;
      ST_READ:  state_next = ST_ACC;
      ST_ACC:   state_next = tap_last ? ST_DIV : ST_READ;
      ST_DIV: begin
        if (div_done_r && div_done_g && div_done_b) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cfg_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
      end
      ST_OUT:  out_valid = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cfg_width    <= FRAME_WIDTH_RESET;
      cfg_height   <= FRAME_HEIGHT_RESET;
      in_col       <= '0;
      in_row       <= '0;
      in_slot      <= '0;
      out_col      <= '0;
      out_row      <= '0;
      out_slot     <= '0;
      frame_loaded <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        if (cfg_index == REG_FRAME_WIDTH) begin
          cfg_width <= cfg_data;
        end else begin
          cfg_height <= cfg_data;
        end
        in_col       <= '0;
        in_row       <= '0;
        in_slot      <= '0;
        out_col      <= '0;
        out_row      <= '0;
        out_slot     <= '0;
        frame_loaded <= 1'b0;
      end else if (pixel_take) begin
        if (WW'(in_col) + WW'(1) >= w_eff) begin
          in_col <= '0;
          if (HW'(in_row) + HW'(1) >= h_eff) begin
            frame_loaded <= 1'b1;
          end else begin
            in_row  <= in_row + 1'b1;
            in_slot <= (in_slot == SLW'(LINE_SLOTS - 1)) ? '0 : in_slot + 1'b1;
          end
        end else begin
          in_col <= in_col + 1'b1;
        end
      end else if (out_xfer) begin
        if (out_last) begin
          in_col       <= '0;
          in_row       <= '0;
          in_slot      <= '0;
          out_col      <= '0;
          out_row      <= '0;
          out_slot     <= '0;
          frame_loaded <= 1'b0;
        end else if (WW'(out_col) + WW'(1) >= w_eff) begin
          out_col  <= '0;
          out_row  <= out_row + 1'b1;
          out_slot <= (out_slot == SLW'(LINE_SLOTS - 1)) ? '0 : out_slot + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // Window walk, accumulation and capture of the quotients for output.
  always_ff @(posedge clk) begin
    case (state)
      ST_CHECK: begin
        ky    <= '0;
        kx    <= '0;
        sum_r <= '0;
        sum_g <= '0;
        sum_b <= '0;
        count <= '0;
      end
      ST_READ: tap_in <= tap_ok;
      ST_ACC: begin
        if (tap_in) begin
          sum_r <= sum_r + SUMW'(rd_data[3*CH_W-1:2*CH_W]);
          sum_g <= sum_g + SUMW'(rd_data[2*CH_W-1:CH_W]);
          sum_b <= sum_b + SUMW'(rd_data[CH_W-1:0]);
          count <= count + 1'b1;
        end
        if (kx == KW'(KSIZE - 1)) begin
          kx <= '0;
          ky <= ky + 1'b1;
        end else begin
          kx <= kx + 1'b1;
        end
      end
      ST_DIV: begin
        out_red   <= q_r;
        out_green <= q_g;
        out_blue  <= q_b;
        out_last  <= (HW'(out_row) + HW'(1) >= h_eff) && (WW'(out_col) + WW'(1) >= w_eff);
      end
      default: begin
      end
    endcase
  end

  assign frame_end = out_last;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 7x7 RGB box blur. Frames of assorted geometry
// are streamed in with random bursts and output stalls, and every output
// transfer is compared against an in-bench window-mean predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bb7_pkg::*;

  localparam int MAXW = 2048;
  localparam int MAXH = 2048;
  localparam int RAD = 3;
  localparam int SLOTS = 8;
  localparam int SETTLE = 150;
  localparam int ITEM_TARGET = 660;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic last;
  } blur_pix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_PIXEL;
  logic [CH_W-1:0] in_red = '0;
  logic [CH_W-1:0] in_green = '0;
  logic [CH_W-1:0] in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  blur_pix_t mean_queue[$];
  logic [PIX_W-1:0] row_mem [0:SLOTS*MAXW-1];
  int unsigned geo_width, geo_height;
  int unsigned px_col, px_row, res_col, res_row;
  bit frame_full;
  int errors = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int items_sent = 0;

  box_blur_7x7_rgb u_top (.*);

  always #10 clk = ~clk;

  function automatic int unsigned clamp_geo(int unsigned v, int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int unsigned mem_addr(int unsigned r, int unsigned c);
    return (r % SLOTS) * MAXW + c;
  endfunction

  function automatic void restart_positions();
    px_col = 0;
    px_row = 0;
    res_col = 0;
    res_row = 0;
    frame_full = 1'b0;
  endfunction

  function automatic void predict_mean(logic cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                       logic [CH_W-1:0] b);
    int unsigned w, h, nr, nc, sr, sg, sb, cnt, y, x;
    logic [PIX_W-1:0] p;
    blur_pix_t e;
    w = clamp_geo(geo_width, MAXW);
    h = clamp_geo(geo_height, MAXH);
    if (cmd == CMD_PIXEL) begin
      if (frame_full) return;
      row_mem[mem_addr(px_row, px_col)] = {r, g, b};
      if (px_col + 1 >= w) begin
        px_col = 0;
        if (px_row + 1 >= h) frame_full = 1'b1;
        else px_row++;
      end else begin
        px_col++;
      end
    end
    if (!frame_full) begin
      nr = (res_row + RAD > h - 1) ? h - 1 : res_row + RAD;
      nc = (res_col + RAD > w - 1) ? w - 1 : res_col + RAD;
      if (!(px_row > nr || (px_row == nr && px_col > nc))) return;
    end
    sr = 0;
    sg = 0;
    sb = 0;
    cnt = 0;
    for (int dy = -RAD; dy <= RAD; dy++) begin
      for (int dx = -RAD; dx <= RAD; dx++) begin
        if (int'(res_row) + dy >= 0 && int'(res_row) + dy < int'(h) &&
            int'(res_col) + dx >= 0 && int'(res_col) + dx < int'(w)) begin
          y = res_row + dy;
          x = res_col + dx;
          p = row_mem[mem_addr(y, x)];
          sr += p[23:16];
          sg += p[15:8];
          sb += p[7:0];
          cnt++;
        end
      end
    end
    e.red = CH_W'(sr / cnt);
    e.green = CH_W'(sg / cnt);
    e.blue = CH_W'(sb / cnt);
    e.last = (res_row + 1 >= h && res_col + 1 >= w);
    mean_queue.push_back(e);
    if (e.last) restart_positions();
    else if (res_col + 1 >= w) begin
      res_col = 0;
      res_row++;
    end else begin
      res_col++;
    end
  endfunction

  // Leaves in_valid high when the burst continues, so the next call must follow at once.
  task automatic send_item(logic cmd, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                           logic [CH_W-1:0] b);
    in_valid <= 1'b1;
    command <= cmd;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_mean(cmd, r, g, b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_pixel();
    send_item(CMD_PIXEL, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mean_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FRAME_WIDTH) begin
      geo_width = val;
      restart_positions();
    end else if (idx == REG_FRAME_HEIGHT) begin
      geo_height = val;
      restart_positions();
    end
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic drain_frame();
    while (frame_full) begin
      if ($urandom_range(0, 5) == 0) send_pixel();
      else send_item(CMD_FLUSH, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_reset_geometry();
    send_item(CMD_FLUSH, 8'h00, 8'h00, 8'h00);
    repeat (5) send_pixel();
  endtask

  task automatic test_extremes();
    set_geometry(12'd1, 12'd1);
    send_item(CMD_PIXEL, 8'hFF, 8'h00, 8'hFF);
    set_geometry(12'd0, 12'd0);
    send_item(CMD_PIXEL, 8'h00, 8'hFF, 8'h00);
    set_geometry(12'd2048, 12'd1);
    send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_item(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    repeat (4) send_item(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    set_geometry(12'd4095, 12'd4095);
    repeat (3) send_pixel();
    set_geometry(12'd2, 12'd2048);
    repeat (10) send_pixel();
    wait_idle();
    write_reg(4'd5, 12'hABC);
    send_pixel();
  endtask

  task automatic test_drain_rules();
    set_geometry(12'd3, 12'd2);
    send_item(CMD_FLUSH, $urandom, $urandom, $urandom);
    repeat (6) send_pixel();
    send_pixel();
    send_pixel();
    drain_frame();
    send_item(CMD_FLUSH, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_frames();
    int first_count;
    int w, h, npix;
    first_count = items_sent;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 2) != 0 || items_sent == first_count) begin
        w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
        set_geometry(CFG_W'(w), CFG_W'(h));
      end
      npix = clamp_geo(geo_width, MAXW) * clamp_geo(geo_height, MAXH);
      if ($urandom_range(0, 7) == 0) npix = $urandom_range(1, npix);
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(CMD_FLUSH, $urandom, $urandom, $urandom);
        end
        send_pixel();
      end
      drain_frame();
      if ($urandom_range(0, 4) == 0) wait_idle();
    end
  endtask

  always @(posedge clk) begin
    blur_pix_t e;
    if (!rst && out_valid && !out_stall) begin
      if (mean_queue.size() == 0) begin
        $display("%0t: unexpected transfer rgb=%h %h %h last=%b", $time,
                 out_red, out_green, out_blue, frame_end);
        errors++;
      end else begin
        e = mean_queue.pop_front();
        if (e.red !== out_red || e.green !== out_green || e.blue !== out_blue ||
            e.last !== frame_end) begin
          $display("%0t: mismatch expected rgb=%h %h %h last=%b actual rgb=%h %h %h last=%b",
                   $time, e.red, e.green, e.blue, e.last,
                   out_red, out_green, out_blue, frame_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    for (int i = 0; i < SLOTS * MAXW; i++) row_mem[i] = '0;
    geo_width = FRAME_WIDTH_RESET;
    geo_height = FRAME_HEIGHT_RESET;
    restart_positions();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_geometry();
    test_extremes();
    test_drain_rules();
    test_random_frames();
    wait_idle();
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #40ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
src/bb7_pkg.sv
src/bb7_line_store.sv
src/bb7_divider.sv
src/box_blur_7x7_rgb.sv
tb/tb.sv
